// ===== hw/rtl/dfe_pkg.sv =====
// Shared types, constants and pixel functions for the dithered framebuffer engine.
package dfe_pkg;

	localparam int SCREEN_WIDTH  = 176;
	localparam int SCREEN_HEIGHT = 176;
	localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(STORE_SIZE);
	localparam int PIX_W         = 3;

	localparam logic [15:0] COLOR_KEEP_MASK = 16'b1110011100011100;
	localparam logic [15:0] RED_FULL        = 16'hF800;
	localparam logic [15:0] GREEN_FULL      = 16'h07E0;
	localparam logic [15:0] BLUE_FULL       = 16'h001F;

	localparam logic [2:0] BAYER_EVEN_EVEN = 3'd1;
	localparam logic [2:0] BAYER_EVEN_ODD  = 3'd5;
	localparam logic [2:0] BAYER_ODD_EVEN  = 3'd7;
	localparam logic [2:0] BAYER_ODD_ODD   = 3'd3;

	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_GET  = 2'd1,
		ACT_FILL = 2'd2
	} dfe_action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ_WAIT,
		ST_FILL,
		ST_DONE
	} dfe_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  x_end;
		logic [7:0]  y_end;
		logic [15:0] color;
	} dfe_req_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic        status;
	} dfe_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic clear_wr;
		logic pix_wr;
		logic rd_en;
		logic walk_step;
		logic out_load;
	} dfe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] action;
		logic       on_xy;
		logic       fill_ok;
		logic       fill_last;
		logic       clear_last;
		logic       out_free;
	} dfe_stat_t;

	function automatic logic col_on_screen(input logic [7:0] c);
		return {1'b0, c} < 9'(SCREEN_WIDTH);
	endfunction

	function automatic logic row_on_screen(input logic [7:0] r);
		return {1'b0, r} < 9'(SCREEN_HEIGHT);
	endfunction

	function automatic logic [2:0] bayer_level(input logic y0, input logic x0);
		logic [2:0] lvl;
		case ({y0, x0})
			2'b00:   lvl = BAYER_EVEN_EVEN;
			2'b01:   lvl = BAYER_EVEN_ODD;
			2'b10:   lvl = BAYER_ODD_EVEN;
			default: lvl = BAYER_ODD_ODD;
		endcase
		return lvl;
	endfunction

	// Keep the channel carries: red out of bit 16, green out of 11, blue out of 5.
	function automatic logic [PIX_W-1:0] dither_color(input logic [15:0] color,
			input logic x0, input logic y0);
		logic [2:0]  lvl;
		logic [15:0] spread;
		logic [16:0] sum;
		lvl    = bayer_level(y0, x0);
		spread = (16'(lvl) << 13) | (16'(lvl) << 8) | (16'(lvl) << 2);
		sum    = {1'b0, color & COLOR_KEEP_MASK} + {1'b0, spread};
		return {sum[5], sum[11], sum[16]};
	endfunction

	function automatic logic [15:0] expand_pixel(input logic [PIX_W-1:0] px);
		return (px[0] ? RED_FULL : 16'd0) | (px[1] ? GREEN_FULL : 16'd0) |
			(px[2] ? BLUE_FULL : 16'd0);
	endfunction

endpackage

// ===== hw/rtl/dfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/dfe_datapath.sv =====
// Datapath: request capture, fill walker, clear counter, pixel store and result register.
module dfe_datapath
	import dfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dfe_req_t  req,
	input  dfe_cmd_t  cmd,
	input  logic      rsp_ready,
	output dfe_stat_t stat,
	output logic      rsp_valid,
	output dfe_rsp_t  rsp
);

	logic [1:0]        action_q;
	logic [7:0]        x_q;
	logic [7:0]        x_end_q;
	logic [7:0]        y_end_q;
	logic [15:0]       color_q;
	logic              on_xy_q;
	logic              fill_ok_q;
	logic              status_q;
	logic [7:0]        walk_col_q;
	logic [7:0]        walk_row_q;
	logic [ADDR_W-1:0] clear_addr_q;
	logic              rsp_valid_q;
	dfe_rsp_t          rsp_q;

	logic              req_on_xy;
	logic              req_on_end;
	logic [7:0]        req_xe_clip;
	logic [7:0]        req_ye_clip;
	logic              req_status;
	logic [ADDR_W-1:0] pix_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [PIX_W-1:0]  wr_data;
	logic [PIX_W-1:0]  rd_data;
	logic              walk_row_end;

	always_comb begin
		req_on_xy   = col_on_screen(req.x) && row_on_screen(req.y);
		req_on_end  = col_on_screen(req.x_end) && row_on_screen(req.y_end);
		req_xe_clip = col_on_screen(req.x_end) ? req.x_end : 8'(SCREEN_WIDTH - 1);
		req_ye_clip = row_on_screen(req.y_end) ? req.y_end : 8'(SCREEN_HEIGHT - 1);
		case (req.action)
			ACT_SET, ACT_GET: req_status = !req_on_xy;
			ACT_FILL:         req_status = !req_on_xy || !req_on_end;
			default:          req_status = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= req.action;
			x_q       <= req.x;
			x_end_q   <= req_xe_clip;
			y_end_q   <= req_ye_clip;
			color_q   <= req.color;
			on_xy_q   <= req_on_xy;
			fill_ok_q <= req_on_xy && (req.x <= req_xe_clip) && (req.y <= req_ye_clip);
			status_q  <= req_status;
		end
	end

	assign walk_row_end = (walk_col_q == x_end_q);

	// Walker starts at the request's corner; single-pixel actions use it as their address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_col_q <= '0;
			walk_row_q <= '0;
		end else if (cmd.load) begin
			walk_col_q <= req.x;
			walk_row_q <= req.y;
		end else if (cmd.walk_step) begin
			if (walk_row_end) begin
				walk_col_q <= x_q;
				walk_row_q <= walk_row_q + 8'd1;
			end else begin
				walk_col_q <= walk_col_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clear_addr_q <= clear_addr_q + ADDR_W'(1);
		end
	end

	assign pix_addr = ADDR_W'(walk_row_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(walk_col_q);
	assign wr_addr  = cmd.clear_wr ? clear_addr_q : pix_addr;
	assign wr_data  = cmd.clear_wr ? '0 : dither_color(color_q, walk_col_q[0], walk_row_q[0]);

	dfe_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.clear_wr || cmd.pix_wr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (pix_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.pixel_color <= (action_q == ACT_GET && on_xy_q) ? expand_pixel(rd_data) : 16'd0;
			rsp_q.status      <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		stat.action     = action_q;
		stat.on_xy      = on_xy_q;
		stat.fill_ok    = fill_ok_q;
		stat.fill_last  = walk_row_end && (walk_row_q == y_end_q);
		stat.clear_last = (clear_addr_q == ADDR_W'(STORE_SIZE - 1));
		stat.out_free   = !rsp_valid_q || rsp_ready;
	end

endmodule

// ===== hw/rtl/dfe_ctrl.sv =====
// Controller state machine: clearing pass, request dispatch, fill walk and result hand-off.
module dfe_ctrl
	import dfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  dfe_stat_t stat,
	output logic      req_ready,
	output dfe_cmd_t  cmd
);

	dfe_state_t state_q;
	dfe_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic finish;
		finish    = 1'b0;
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.action)
					ACT_SET: begin
						cmd.pix_wr = stat.on_xy;
						finish     = 1'b1;
					end
					ACT_GET: begin
						if (stat.on_xy) begin
							cmd.rd_en = 1'b1;
							state_d   = ST_READ_WAIT;
						end else begin
							finish = 1'b1;
						end
					end
					ACT_FILL: begin
						if (stat.fill_ok) begin
							state_d = ST_FILL;
						end else begin
							finish = 1'b1;
						end
					end
					default: finish = 1'b1;
				endcase
			end
			ST_FILL: begin
				cmd.pix_wr    = 1'b1;
				cmd.walk_step = 1'b1;
				finish        = stat.fill_last;
			end
			ST_READ_WAIT: finish = 1'b1;
			ST_DONE:      finish = 1'b1;
			default:      state_d = ST_IDLE;
		endcase
		// Hand the result over when the output register frees up, else hold in DONE.
		if (finish) begin
			if (stat.out_free) begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end else begin
				state_d = ST_DONE;
			end
		end
	end

endmodule

// ===== hw/rtl/dithered_framebuffer_engine_unit.sv =====
// Top level of the dithered framebuffer engine.
// Framebuffer of 3-bit RGB pixels (SCREEN_WIDTH x SCREEN_HEIGHT, 176 x 176) with a 2x2
// ordered dither on write and RGB565 expansion on read. After reset the block clears all
// STORE_SIZE (30976) pixels to black, one pixel per cycle, with req_ready low. Then a set
// writes in the dispatch state, a get answers from read-wait (registered memory read), and
// a fill writes one clipped-rectangle pixel per cycle, since the store has one write port.
// A result goes to an output register, so the next request is taken while it waits.
module dithered_framebuffer_engine_unit
	import dfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dfe_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output dfe_rsp_t rsp
);

	dfe_cmd_t  cmd;
	dfe_stat_t stat;

	dfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	dfe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/dfe_checker.sv =====
// Port-level checks for the dithered framebuffer engine, bound to the top level.
module dfe_checker
	import dfe_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input dfe_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input dfe_rsp_t rsp
);

	// A waiting result beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is still at work");

	// An off-screen result never carries a colour.
	a_status_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.pixel_color == 16'd0)
		else $error("colour returned with an off-screen status");

	// Each channel reads back fully on or fully off.
	a_full_channels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pixel_color[15:11] == 5'h00 || rsp.pixel_color[15:11] == 5'h1F)
			&& (rsp.pixel_color[10:5] == 6'h00 || rsp.pixel_color[10:5] == 6'h3F)
			&& (rsp.pixel_color[4:0] == 5'h00 || rsp.pixel_color[4:0] == 5'h1F))
		else $error("read-back colour has a partial channel");

endmodule

bind dithered_framebuffer_engine_unit dfe_checker u_dfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
